### rtl/core/hgni_pkg.sv
// ----------------------------------------------------------------------------
// hgni_pkg
// Shared widths, status codes, register indexes and the configuration
// bundle for the halo ghost node index resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package hgni_pkg;

	// field widths
	localparam int NODE_W   = 24;
	localparam int COORD_W  = 12;
	localparam int STRIDE_W = 24;
	localparam int IDX_W    = 28;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;

	// internal arithmetic widths
	localparam int FROW_W  = 14;   // extent_x + 2G + 1
	localparam int IRANK_W = 17;   // halo nodes in one interior layer
	localparam int FRANK_W = 25;   // nodes in one full layer
	localparam int WIDE_W  = 44;   // packed index arithmetic
	localparam int PROD_W  = 42;   // registered products
	localparam int LOC_W   = 26;   // coordinates before band check
	localparam int NARROW_W = 16;  // coordinates inside the band

	localparam int GHOST_ROWS_DEF = 1;

	typedef logic [1:0] status_t;

	localparam status_t ST_OWNED   = 2'd0;
	localparam status_t ST_GHOST   = 2'd1;
	localparam status_t ST_OUTSIDE = 2'd2;
	localparam status_t ST_RANGE   = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ORIGIN_X     = 3'd0;
	localparam cfg_idx_t REG_ORIGIN_Y     = 3'd1;
	localparam cfg_idx_t REG_ORIGIN_Z     = 3'd2;
	localparam cfg_idx_t REG_EXTENT_X     = 3'd3;
	localparam cfg_idx_t REG_EXTENT_Y     = 3'd4;
	localparam cfg_idx_t REG_EXTENT_Z     = 3'd5;
	localparam cfg_idx_t REG_ROW_STRIDE   = 3'd6;
	localparam cfg_idx_t REG_PLANE_STRIDE = 3'd7;

	// configuration plus values derived from it
	typedef struct packed {
		logic [COORD_W-1:0]  ox;
		logic [COORD_W-1:0]  oy;
		logic [COORD_W-1:0]  oz;
		logic [COORD_W-1:0]  ex;
		logic [COORD_W-1:0]  ey;
		logic [COORD_W-1:0]  ez;
		logic [STRIDE_W-1:0] rs;
		logic [STRIDE_W-1:0] ps;
		logic                is3d;
		logic [FROW_W-1:0]   frow;
		logic [IRANK_W-1:0]  irank;
		logic [FRANK_W-1:0]  frank;
		logic [WIDE_W-1:0]   base_part;
		logic [WIDE_W-1:0]   base_top;
		logic [WIDE_W-1:0]   base_int;
		logic [WIDE_W-1:0]   base_apex;
		logic [WIDE_W-1:0]   total;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/core/hgni_if.sv
// ----------------------------------------------------------------------------
// hgni channel interfaces
// Valid/ready channels for node numbers in and resolved results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hgni_in_if;
	import hgni_pkg::*;
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] node_number;
	modport source (output valid, output node_number, input ready);
	modport sink   (input valid, input node_number, output ready);
endinterface

interface hgni_out_if;
	import hgni_pkg::*;
	logic             valid;
	logic             ready;
	status_t          status;
	logic [IDX_W-1:0] ghost_index;
	modport source (output valid, output status, output ghost_index, input ready);
	modport sink   (input valid, input status, input ghost_index, output ready);
endinterface

`default_nettype wire

### rtl/core/halo_ghost_node_index_top.sv
// ----------------------------------------------------------------------------
// halo_ghost_node_index_top
// Resolves a global grid node number to owned / ghost / outside and gives
// the packed halo index of ghost nodes.
// ----------------------------------------------------------------------------
// Accepts one node number per clock while results are taken and returns
// one result per node, in order: two 24-stage pipelined dividers in a row
// (node by plane stride, then the in-plane rest by row stride), then four
// stages for band check, products, layout select and the final range check.
// When the result is not taken the whole pipeline holds, so input ready
// drops only while an output transfer is pending. The user must write
// configuration through the plain write port only while no item is in
// flight, which the block does not enforce. Derived sizes are registered.
`default_nettype none

module halo_ghost_node_index_top #(
	parameter int GHOST_ROWS = hgni_pkg::GHOST_ROWS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	hgni_in_if.sink                       node_in,
	hgni_out_if.source                    result_out,
	input  wire                           cfg_we,
	input  wire [hgni_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire [hgni_pkg::CFG_W-1:0]     cfg_wdata
);
	import hgni_pkg::*;

	cfg_t              cfg;
	logic              adv;
	logic [NODE_W-1:0] m;
	logic              d1_v, d2_v;
	logic [NODE_W-1:0] q1, r1, m1, rnum, q2, r2, rank2;

	// whole pipeline advances unless a result is waiting
	assign adv           = !result_out.valid || result_out.ready;
	assign node_in.ready = adv;
	assign m             = node_in.node_number - NODE_W'(1);

	hgni_cfg #(.GHOST_ROWS(GHOST_ROWS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// layer split
	hgni_div u_div_plane (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (node_in.valid),
		.dividend (m),
		.divisor  (cfg.ps),
		.side_in  (m),
		.out_v    (d1_v),
		.quot     (q1),
		.rem      (r1),
		.side_out (m1)
	);

	// 2D uses the whole zero-based number as in-plane position
	assign rnum = cfg.is3d ? r1 : m1;

	// row / column split
	hgni_div u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (d1_v),
		.dividend (rnum),
		.divisor  (cfg.rs),
		.side_in  (q1),
		.out_v    (d2_v),
		.quot     (q2),
		.rem      (r2),
		.side_out (rank2)
	);

	hgni_post #(.GHOST_ROWS(GHOST_ROWS)) u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.cfg         (cfg),
		.in_v        (d2_v),
		.row_raw     (q2),
		.col_raw     (r2),
		.rank_raw    (rank2),
		.out_v       (result_out.valid),
		.status      (result_out.status),
		.ghost_index (result_out.ghost_index)
	);

	// only a ghost result carries an index
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && (result_out.status != ST_GHOST)) |->
		(result_out.ghost_index == '0))
		else $error("nonzero index on non-ghost result");

	// a new result appears only after the pipe moved
	a_rise_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_out.valid) |-> $past(node_in.ready))
		else $error("result appeared while pipeline held");

	// effective strides never zero
	a_stride: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.rs != '0) && (cfg.ps != '0))
		else $error("zero effective stride");

endmodule

`default_nettype wire

### rtl/core/hgni_div.sv
// ----------------------------------------------------------------------------
// hgni_div
// Pipelined restoring divider: one quotient bit per stage, a side word
// travels along with each transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module hgni_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  wire                        in_v,
	input  wire [hgni_pkg::NODE_W-1:0] dividend,
	input  wire [hgni_pkg::NODE_W-1:0] divisor,
	input  wire [hgni_pkg::NODE_W-1:0] side_in,
	output logic                       out_v,
	output logic [hgni_pkg::NODE_W-1:0] quot,
	output logic [hgni_pkg::NODE_W-1:0] rem,
	output logic [hgni_pkg::NODE_W-1:0] side_out
);
	import hgni_pkg::*;

	logic [NODE_W-1:0] rem_s  [NODE_W];
	logic [NODE_W-1:0] dq_s   [NODE_W];
	logic [NODE_W-1:0] side_s [NODE_W];
	logic              v_s    [NODE_W];

	for (genvar i = 0; i < NODE_W; i++) begin : g_stage
		logic [NODE_W-1:0] rem_p, dq_p, side_p;
		logic              v_p;
		logic [NODE_W:0]   trial, diff;
		logic              ge;

		if (i == 0) begin : g_first
			assign rem_p  = '0;
			assign dq_p   = dividend;
			assign side_p = side_in;
			assign v_p    = in_v;
		end else begin : g_next
			assign rem_p  = rem_s[i-1];
			assign dq_p   = dq_s[i-1];
			assign side_p = side_s[i-1];
			assign v_p    = v_s[i-1];
		end

		// shift in next dividend bit, subtract when it fits
		assign trial = {rem_p, dq_p[NODE_W-1]};
		assign diff  = trial - {1'b0, divisor};
		assign ge    = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? diff[NODE_W-1:0] : trial[NODE_W-1:0];
				dq_s[i]   <= {dq_p[NODE_W-2:0], ge};
				side_s[i] <= side_p;
			end
		end
	end

	assign out_v    = v_s[NODE_W-1];
	assign quot     = dq_s[NODE_W-1];
	assign rem      = rem_s[NODE_W-1];
	assign side_out = side_s[NODE_W-1];

endmodule

`default_nettype wire

### rtl/core/hgni_cfg.sv
// ----------------------------------------------------------------------------
// hgni_cfg
// Configuration registers and the halo layout sizes derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module hgni_cfg #(
	parameter int GHOST_ROWS = hgni_pkg::GHOST_ROWS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [hgni_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire [hgni_pkg::CFG_W-1:0]    cfg_wdata,
	output hgni_pkg::cfg_t               cfg
);
	import hgni_pkg::*;

	localparam logic [7:0] G_V    = 8'(GHOST_ROWS);
	localparam logic [7:0] IROW_V = 8'(2 * GHOST_ROWS + 1);

	logic [COORD_W-1:0]  ox_q, oy_q, oz_q, ex_q, ey_q, ez_q;
	logic [STRIDE_W-1:0] rs_q, ps_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
			ex_q <= COORD_W'(1);
			ey_q <= COORD_W'(1);
			ez_q <= '0;
			rs_q <= STRIDE_W'(1);
			ps_q <= STRIDE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ORIGIN_X:     ox_q <= cfg_wdata[COORD_W-1:0];
				REG_ORIGIN_Y:     oy_q <= cfg_wdata[COORD_W-1:0];
				REG_ORIGIN_Z:     oz_q <= cfg_wdata[COORD_W-1:0];
				REG_EXTENT_X:     ex_q <= cfg_wdata[COORD_W-1:0];
				REG_EXTENT_Y:     ey_q <= cfg_wdata[COORD_W-1:0];
				REG_EXTENT_Z:     ez_q <= cfg_wdata[COORD_W-1:0];
				REG_ROW_STRIDE:   rs_q <= cfg_wdata[STRIDE_W-1:0];
				REG_PLANE_STRIDE: ps_q <= cfg_wdata[STRIDE_W-1:0];
				default:          ;
			endcase
		end
	end

	// derived sizes, refreshed every cycle; settle long before an item needs them
	logic [FROW_W-1:0]  frow;
	logic [FROW_W:0]    fy_sum, yi_sum;
	logic [31:0]        irank_c, frank_c, bpart_c, btop_c;
	logic [31:0]        bint_c, znir_c, irfr_c;
	logic [IRANK_W-1:0] irank_q;
	logic [FRANK_W-1:0] frank_q;
	logic [31:0]        bpart_q, btop_q, bint_q, znir_q, irfr_q;

	assign frow    = FROW_W'(ex_q) + FROW_W'(IROW_V);
	assign fy_sum  = (FROW_W+1)'(frow) + (FROW_W+1)'(ey_q);
	assign yi_sum  = (FROW_W+1)'(ey_q) + (FROW_W+1)'(IROW_V);
	assign irank_c = 32'(IROW_V) * 32'(fy_sum);
	assign frank_c = 32'(frow) * 32'(yi_sum);
	assign bpart_c = 32'(G_V) * 32'(frow);
	assign btop_c  = 32'(ey_q) * 32'(IROW_V);
	assign bint_c  = 32'(G_V) * 32'(frank_q);
	assign znir_c  = 32'(ez_q) * 32'(irank_q);
	assign irfr_c  = 32'(IROW_V) * 32'(frank_q);

	always_ff @(posedge clk) begin
		irank_q <= irank_c[IRANK_W-1:0];
		frank_q <= frank_c[FRANK_W-1:0];
		bpart_q <= bpart_c;
		btop_q  <= bpart_c + btop_c;
		bint_q  <= bint_c;
		znir_q  <= znir_c;
		irfr_q  <= irfr_c;
	end

	// zero stride behaves as one
	always_comb begin
		cfg.ox        = ox_q;
		cfg.oy        = oy_q;
		cfg.oz        = oz_q;
		cfg.ex        = ex_q;
		cfg.ey        = ey_q;
		cfg.ez        = ez_q;
		cfg.rs        = (rs_q == '0) ? STRIDE_W'(1) : rs_q;
		cfg.ps        = (ps_q == '0) ? STRIDE_W'(1) : ps_q;
		cfg.is3d      = (ez_q != '0);
		cfg.frow      = frow;
		cfg.irank     = irank_q;
		cfg.frank     = frank_q;
		cfg.base_part = WIDE_W'(bpart_q);
		cfg.base_top  = WIDE_W'(btop_q);
		cfg.base_int  = WIDE_W'(bint_q);
		cfg.base_apex = WIDE_W'(bint_q) + WIDE_W'(znir_q);
		cfg.total     = (ez_q != '0) ? WIDE_W'(irfr_q) + WIDE_W'(znir_q)
		                             : WIDE_W'(irank_q);
	end

endmodule

`default_nettype wire

### rtl/core/hgni_post.sv
// ----------------------------------------------------------------------------
// hgni_post
// Four-stage back end: band check, products, layout select, final index
// and range check.
// ----------------------------------------------------------------------------
`default_nettype none

module hgni_post #(
	parameter int GHOST_ROWS = hgni_pkg::GHOST_ROWS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire hgni_pkg::cfg_t          cfg,
	input  wire                          in_v,
	input  wire [hgni_pkg::NODE_W-1:0]   row_raw,
	input  wire [hgni_pkg::NODE_W-1:0]   col_raw,
	input  wire [hgni_pkg::NODE_W-1:0]   rank_raw,
	output logic                         out_v,
	output hgni_pkg::status_t            status,
	output logic [hgni_pkg::IDX_W-1:0]   ghost_index
);
	import hgni_pkg::*;

	localparam logic signed [LOC_W-1:0]    G_L  = LOC_W'(GHOST_ROWS);
	localparam logic signed [NARROW_W-1:0] G_N  = NARROW_W'(GHOST_ROWS);
	localparam logic signed [NARROW_W-1:0] IR_N = NARROW_W'(2 * GHOST_ROWS + 1);
	localparam logic signed [WIDE_W-1:0]   G_W  = WIDE_W'(GHOST_ROWS);
	localparam logic signed [WIDE_W-1:0]   IDX_MAX = WIDE_W'({IDX_W{1'b1}});

	// ---- stage 1: relative coordinates and band check ----
	logic signed [LOC_W-1:0] colw, roww, rankw, xw, yw, zw;
	logic                    in_x, in_y, in_z, owned_c, outside_c;

	assign colw  = $signed({2'b00, col_raw})  - $signed(LOC_W'(cfg.ox));
	assign roww  = $signed({2'b00, row_raw})  - $signed(LOC_W'(cfg.oy));
	assign rankw = $signed({2'b00, rank_raw}) - $signed(LOC_W'(cfg.oz));
	assign xw    = $signed(LOC_W'(cfg.ex));
	assign yw    = $signed(LOC_W'(cfg.ey));
	assign zw    = $signed(LOC_W'(cfg.ez));
	assign in_x  = (colw >= 0) && (colw < xw);
	assign in_y  = (roww >= 0) && (roww < yw);
	assign in_z  = (rankw >= 0) && (rankw < zw);
	assign owned_c   = in_x && in_y && (!cfg.is3d || in_z);
	assign outside_c = (roww < -G_L) || (roww > yw + G_L) ||
	                   (colw < -G_L) || (colw > xw + G_L) ||
	                   (cfg.is3d && ((rankw < -G_L) || (rankw > zw + G_L)));

	logic                       v_s1, owned_s1, outside_s1;
	logic signed [NARROW_W-1:0] col_s1, row_s1, rank_s1;

	// ---- stage 2: products ----
	logic signed [NARROW_W-1:0] rpg, rmy, kpg, kmz, frow_n, ey_n, ez_n;
	logic signed [FRANK_W:0]    frank_n;
	logic signed [IRANK_W:0]    irank_n;
	logic signed [PROD_W-1:0]   pa_c, pb_c, pc_c, ka_c, kb_c, kc_c;

	assign frow_n  = $signed(NARROW_W'(cfg.frow));
	assign ey_n    = $signed(NARROW_W'(cfg.ey));
	assign ez_n    = $signed(NARROW_W'(cfg.ez));
	assign frank_n = $signed({1'b0, cfg.frank});
	assign irank_n = $signed({1'b0, cfg.irank});
	assign rpg     = row_s1 + G_N;
	assign rmy     = row_s1 - ey_n;
	assign kpg     = rank_s1 + G_N;
	assign kmz     = rank_s1 - ez_n;
	assign pa_c    = rpg * frow_n;
	assign pb_c    = row_s1 * IR_N;
	assign pc_c    = rmy * frow_n;
	assign ka_c    = kpg * frank_n;
	assign kb_c    = rank_s1 * irank_n;
	assign kc_c    = kmz * frank_n;

	logic                       v_s2, owned_s2, outside_s2;
	logic signed [NARROW_W-1:0] col_s2, row_s2, rank_s2;
	logic signed [PROD_W-1:0]   pa_s2, pb_s2, pc_s2, ka_s2, kb_s2, kc_s2;

	// ---- stage 3: pick the layout arm ----
	logic signed [WIDE_W-1:0] full_c, inpl_c, term_c, plane_c, xe_w, ye_w, ze_w;
	logic signed [WIDE_W-1:0] pa_w, pb_w, pc_w, ka_w, kb_w, kc_w, col_w;

	assign xe_w  = $signed(WIDE_W'(cfg.ex));
	assign ye_w  = $signed(WIDE_W'(cfg.ey));
	assign ze_w  = $signed(WIDE_W'(cfg.ez));
	assign pa_w  = WIDE_W'(pa_s2);
	assign pb_w  = WIDE_W'(pb_s2);
	assign pc_w  = WIDE_W'(pc_s2);
	assign ka_w  = WIDE_W'(ka_s2);
	assign kb_w  = WIDE_W'(kb_s2);
	assign kc_w  = WIDE_W'(kc_s2);
	assign col_w = WIDE_W'(col_s2);
	assign full_c = pa_w + G_W + col_w;

	always_comb begin
		// position inside one plane: rows below, partial rows, rows above
		priority if (row_s2 < 0) begin
			inpl_c = full_c;
		end else if (WIDE_W'(row_s2) < ye_w) begin
			inpl_c = $signed(cfg.base_part) + pb_w + G_W +
			         ((col_s2 < 0) ? col_w : col_w - xe_w);
		end else begin
			inpl_c = $signed(cfg.base_top) + pc_w + G_W + col_w;
		end
		// layer offset in 3D
		priority if (!cfg.is3d) begin
			term_c = '0;
		end else if (rank_s2 < 0) begin
			term_c = ka_w;
		end else if (WIDE_W'(rank_s2) < ze_w) begin
			term_c = $signed(cfg.base_int) + kb_w;
		end else begin
			term_c = $signed(cfg.base_apex) + kc_w;
		end
		plane_c = (!cfg.is3d || ((rank_s2 >= 0) && (WIDE_W'(rank_s2) < ze_w)))
		          ? inpl_c : full_c;
	end

	logic                     v_s3, owned_s3, outside_s3;
	logic signed [WIDE_W-1:0] term_s3, plane_s3;

	// ---- stage 4: sum and range check ----
	logic signed [WIDE_W-1:0] g_c;
	status_t                  st_c;
	logic [IDX_W-1:0]         idx_c;

	assign g_c = term_s3 + plane_s3;

	always_comb begin
		idx_c = '0;
		priority if (owned_s3) begin
			st_c = ST_OWNED;
		end else if (outside_s3) begin
			st_c = ST_OUTSIDE;
		end else if ((g_c < 0) || (g_c >= $signed(cfg.total)) || (g_c > IDX_MAX)) begin
			st_c = ST_RANGE;
		end else begin
			st_c  = ST_GHOST;
			idx_c = g_c[IDX_W-1:0];
		end
	end

	logic             v_s4;
	status_t          status_s4;
	logic [IDX_W-1:0] idx_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			owned_s1   <= owned_c;
			outside_s1 <= outside_c;
			col_s1     <= colw[NARROW_W-1:0];
			row_s1     <= roww[NARROW_W-1:0];
			rank_s1    <= rankw[NARROW_W-1:0];

			owned_s2   <= owned_s1;
			outside_s2 <= outside_s1;
			col_s2     <= col_s1;
			row_s2     <= row_s1;
			rank_s2    <= rank_s1;
			pa_s2      <= pa_c;
			pb_s2      <= pb_c;
			pc_s2      <= pc_c;
			ka_s2      <= ka_c;
			kb_s2      <= kb_c;
			kc_s2      <= kc_c;

			owned_s3   <= owned_s2;
			outside_s3 <= outside_s2;
			term_s3    <= term_c;
			plane_s3   <= plane_c;

			status_s4  <= st_c;
			idx_s4     <= idx_c;
		end
	end

	assign out_v       = v_s4;
	assign status      = status_s4;
	assign ghost_index = idx_s4;

endmodule

`default_nettype wire
